// ===== rtl/m3inv_pkg.sv =====
package m3inv_pkg;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int EPS_WIDTH      = 16;
	localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd1;
	localparam int NUM_ELEMS      = 9;

	// adjugate element k = m[p]*m[q] - m[r]*m[s]
	localparam int COF_IDX [NUM_ELEMS][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

endpackage

// ===== rtl/matrix3_inverse_adjugate.sv =====
// Channel  | Signals                        | Contents
// s_axis   | tvalid tready tdata            | input matrix, nine elements
// m_axis   | tvalid tready tdata tuser      | inverse or unchanged matrix, singular flag
// cfg      | cfg_we cfg_wdata               | det_epsilon
//
// One matrix enters per cycle unless a stalled output has backed the pipeline up to
// its input. The divider sets the depth: one quotient bit per stage, ELEM_WIDTH+1 stages,
// nine lanes side by side.
// Reset clears only the valid bits and sets det_epsilon to 1.
// A full stage holds while the stage after it is full and stalled, so bubbles close up.
module matrix3_inverse_adjugate #(
	parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// in_e0 .. in_e8 from bit 0 up, zero pad to whole bytes
	input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_e0 .. out_e8 from bit 0 up, zero pad to whole bytes
	output logic [((9*ELEM_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// singular
	output logic m_axis_tuser,
	input  logic cfg_we,
	input  logic [m3inv_pkg::EPS_WIDTH-1:0] cfg_wdata
);

	localparam int W   = ELEM_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int N   = m3inv_pkg::NUM_ELEMS;
	localparam int TDW = ((9*W+7)/8)*8;
	localparam int CW  = 2*W+1;
	localparam int TW  = 3*W+2;
	localparam int DTW = 3*W+3;
	localparam int RW  = ((4*W+2) > (2*W+2*F+2)) ? 4*W+3 : 2*W+2*F+3;
	localparam int NS  = W+8;
	localparam int DS  = 6;

	logic [m3inv_pkg::EPS_WIDTH-1:0] eps_q;
	logic [NS:1] vld_q;
	logic [NS+1:1] rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= m3inv_pkg::EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	always_comb begin
		rdy[NS+1] = m_axis_tready;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign s_axis_tready = rdy[1];
	assign m_axis_tvalid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	logic signed [W-1:0] e_in [N];
	always_comb begin
		for (int k = 0; k < N; k++) begin
			e_in[k] = s_axis_tdata[k*W +: W];
		end
	end

	// elements ride along for the singular case
	logic signed [W-1:0] el_s1 [N], el_s2 [N], el_s3 [N], el_s4 [N], el_s5 [N];
	logic signed [2*W-1:0] p1_s1 [N], p2_s1 [N];
	logic signed [CW-1:0] cof_s2 [N], cof_s3 [N], cof_s4 [N], cof_s5 [N];
	logic signed [CW-1:0] plo_s3 [3], phi_s3 [3];
	logic signed [TW-1:0] term_s4 [3];
	logic signed [DTW-1:0] det_s5;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int k = 0; k < N; k++) begin
				el_s1[k] <= e_in[k];
				p1_s1[k] <= e_in[m3inv_pkg::COF_IDX[k][0]] * e_in[m3inv_pkg::COF_IDX[k][1]];
				p2_s1[k] <= e_in[m3inv_pkg::COF_IDX[k][2]] * e_in[m3inv_pkg::COF_IDX[k][3]];
			end
		end
		if (rdy[2]) begin
			for (int k = 0; k < N; k++) begin
				el_s2[k]  <= el_s1[k];
				cof_s2[k] <= CW'(p1_s1[k]) - CW'(p2_s1[k]);
			end
		end
		// split each first-column cofactor so each product stays near W x W
		if (rdy[3]) begin
			for (int k = 0; k < N; k++) begin
				el_s3[k]  <= el_s2[k];
				cof_s3[k] <= cof_s2[k];
			end
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= el_s2[j] * $signed({1'b0, cof_s2[3*j][W-1:0]});
				phi_s3[j] <= el_s2[j] * $signed(cof_s2[3*j][CW-1:W]);
			end
		end
		if (rdy[4]) begin
			for (int k = 0; k < N; k++) begin
				el_s4[k]  <= el_s3[k];
				cof_s4[k] <= cof_s3[k];
			end
			for (int j = 0; j < 3; j++) begin
				term_s4[j] <= (TW'(phi_s3[j]) <<< W) + TW'(plo_s3[j]);
			end
		end
		if (rdy[5]) begin
			for (int k = 0; k < N; k++) begin
				el_s5[k]  <= el_s4[k];
				cof_s5[k] <= cof_s4[k];
			end
			det_s5 <= DTW'(term_s4[0]) + DTW'(term_s4[1]) + DTW'(term_s4[2]);
		end
	end

	logic [DTW-1:0] adet;
	logic [DTW-1:0] thr;
	logic [RW-1:0] num [N];
	logic [CW-1:0] cabs [N];

	always_comb begin
		adet = det_s5[DTW-1] ? DTW'(-det_s5) : DTW'(det_s5);
		thr  = DTW'(eps_q) << (2*F);
		for (int k = 0; k < N; k++) begin
			cabs[k] = cof_s5[k][CW-1] ? CW'(-cof_s5[k]) : CW'(cof_s5[k]);
			num[k]  = (RW'(cabs[k]) << (2*F+1)) + RW'(adet);
		end
	end

	// division chain: index 0 is stage 6, index d+1 follows quotient bit W-d
	logic [RW-1:0] rem_sd [W+2][N];
	logic [W:0]    quo_sd [W+2][N];
	logic [N-1:0]  neg_sd [W+2];
	logic [RW-1:0] dv_sd  [W+2];
	logic          sing_sd [W+2];
	logic signed [W-1:0] el_sd [W+2][N];

	always_ff @(posedge clk) begin
		if (rdy[DS]) begin
			for (int k = 0; k < N; k++) begin
				rem_sd[0][k] <= num[k];
				quo_sd[0][k] <= '0;
				neg_sd[0][k] <= cof_s5[k][CW-1] ^ det_s5[DTW-1];
				el_sd[0][k]  <= el_s5[k];
			end
			dv_sd[0]   <= RW'(adet) << 1;
			sing_sd[0] <= (adet <= thr);
		end
	end

	for (genvar d = 0; d <= W; d++) begin : g_div
		localparam int BIT = W - d;
		logic [RW-1:0] sub [N];
		logic [N-1:0]  take;
		always_comb begin
			for (int k = 0; k < N; k++) begin
				sub[k]  = dv_sd[d] << BIT;
				take[k] = rem_sd[d][k] >= sub[k];
			end
		end
		always_ff @(posedge clk) begin
			if (rdy[DS+1+d]) begin
				for (int k = 0; k < N; k++) begin
					rem_sd[d+1][k] <= take[k] ? rem_sd[d][k] - sub[k] : rem_sd[d][k];
					quo_sd[d+1][k] <= quo_sd[d][k] | ((W+1)'(take[k]) << BIT);
					el_sd[d+1][k]  <= el_sd[d][k];
				end
				neg_sd[d+1]  <= neg_sd[d];
				dv_sd[d+1]   <= dv_sd[d];
				sing_sd[d+1] <= sing_sd[d];
			end
		end
	end

	logic [W-1:0] res_q [N];
	logic         sing_q;
	logic [W:0]   lim [N];
	logic [W-1:0] res_d [N];

	always_comb begin
		for (int k = 0; k < N; k++) begin
			lim[k] = neg_sd[W+1][k] ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - 1'b1);
			if (sing_sd[W+1]) begin
				res_d[k] = el_sd[W+1][k];
			end else if (quo_sd[W+1][k] > lim[k]) begin
				// saturate to the signed range
				res_d[k] = lim[k][W-1:0];
			end else if (neg_sd[W+1][k]) begin
				res_d[k] = W'(-quo_sd[W+1][k]);
			end else begin
				res_d[k] = quo_sd[W+1][k][W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NS]) begin
			for (int k = 0; k < N; k++) begin
				res_q[k] <= res_d[k];
			end
			sing_q <= sing_sd[W+1];
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int k = 0; k < N; k++) begin
			m_axis_tdata[k*W +: W] = res_q[k];
		end
	end

	assign m_axis_tuser = sing_q;

endmodule

// ===== sim/tb.sv =====
module tb;

	localparam int EW = 32;
	localparam int DW = 9 * EW;
	localparam int LATENCY = EW + 8;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [m3inv_pkg::EPS_WIDTH-1:0] eps;
		logic [DW-1:0]        mat;
		bit                   typed;
		logic [DW:0]          want;
	} row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [DW-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [DW-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we;
	logic [m3inv_pkg::EPS_WIDTH-1:0] cfg_wdata;

	logic [m3inv_pkg::EPS_WIDTH-1:0] eps_now;
	logic [DW:0] inverse_q[$];
	row_t rows[$];
	bit no_idle;
	int errors;
	int matrices_sent;
	int inverses_seen;
	int singular_seen;
	int quiet_cycles;
	int eps_writes;

	matrix3_inverse_adjugate dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// exact adjugate inverse, result packed as {singular, e8 .. e0}
	function automatic logic [DW:0] invert_matrix(logic [DW-1:0] d,
			logic [m3inv_pkg::EPS_WIDTH-1:0] eps);
		logic signed [127:0] m[9];
		logic signed [127:0] adj[9];
		logic signed [127:0] det;
		logic [127:0] adet, thr, num, q, lim;
		logic [DW:0] r;
		bit neg;
		for (int k = 0; k < 9; k++)
			m[k] = $signed(d[EW*k +: EW]);
		for (int k = 0; k < 9; k++)
			adj[k] = m[m3inv_pkg::COF_IDX[k][0]] * m[m3inv_pkg::COF_IDX[k][1]]
				- m[m3inv_pkg::COF_IDX[k][2]] * m[m3inv_pkg::COF_IDX[k][3]];
		det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
		adet = (det < 0) ? -det : det;
		thr = 128'(eps) << (2 * m3inv_pkg::FRAC_BITS_DEF);
		if (adet <= thr)
			return {1'b1, d};
		r = '0;
		for (int k = 0; k < 9; k++) begin
			neg = (adj[k] < 0) != (det < 0);
			num = (((adj[k] < 0) ? -adj[k] : adj[k]) << (2 * m3inv_pkg::FRAC_BITS_DEF + 1))
				+ adet;
			q = num / (adet << 1);
			lim = neg ? (128'd1 << (EW - 1)) : ((128'd1 << (EW - 1)) - 1);
			if (q > lim)
				r[EW*k +: EW] = neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
			else
				r[EW*k +: EW] = neg ? -q[EW-1:0] : q[EW-1:0];
		end
		return r;
	endfunction

	function automatic logic [DW-1:0] pack9(int a0, int a1, int a2, int a3, int a4,
			int a5, int a6, int a7, int a8);
		return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
	endfunction

	function automatic int small_val(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic [DW-1:0] random_matrix();
		int e[9];
		int pick;
		int span;
		pick = $urandom_range(99);
		span = (pick < 85) ? (1 << 18) : 256;
		for (int k = 0; k < 9; k++)
			e[k] = (pick < 30) ? int'($urandom) : small_val(span);
		if (pick >= 30 && pick < 70) begin
			// push the diagonal up so most of these invert cleanly
			e[0] += 32'sh0004_0000;
			e[4] += 32'sh0004_0000;
			e[8] += 32'sh0004_0000;
		end else if (pick >= 70 && pick < 85) begin
			// each third-row element is the first-row one, or that plus the second-row one
			for (int c = 0; c < 3; c++)
				e[6+c] = ($urandom_range(1)) ? e[c] + e[3+c] : e[c];
		end
		return pack9(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
	endfunction

	task automatic report_mismatch(string what, logic [EW-1:0] got, logic [EW-1:0] want);
		$display("MISMATCH item %0d %s: got %h want %h", inverses_seen, what, got, want);
		errors++;
	endtask

	task automatic send_matrix(logic [DW-1:0] mat, bit typed, logic [DW:0] want);
		s_axis_tdata <= mat;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		inverse_q.push_back(typed ? want : invert_matrix(mat, eps_now));
		matrices_sent++;
		if (!no_idle && $urandom_range(99) < 10) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (inverse_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_epsilon(logic [m3inv_pkg::EPS_WIDTH-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		eps_now = v;
		eps_writes++;
	endtask

	task automatic add_row(logic [m3inv_pkg::EPS_WIDTH-1:0] eps, logic [DW-1:0] mat,
			bit typed, logic [DW:0] want);
		row_t r;
		r.eps = eps;
		r.mat = mat;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= no_idle || ($urandom_range(99) >= 10);
	end

	always @(posedge clk) begin
		logic [DW:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (inverse_q.size() == 0) begin
				report_mismatch("result with nothing expected", m_axis_tdata[EW-1:0], '0);
			end else begin
				want = inverse_q.pop_front();
				for (int k = 0; k < 9; k++)
					if (m_axis_tdata[EW*k +: EW] !== want[EW*k +: EW])
						report_mismatch($sformatf("out_e%0d", k), m_axis_tdata[EW*k +: EW],
							want[EW*k +: EW]);
				if (m_axis_tuser !== want[DW])
					report_mismatch("singular", EW'(m_axis_tuser), EW'(want[DW]));
				if (want[DW])
					singular_seen++;
			end
			inverses_seen++;
		end
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [m3inv_pkg::EPS_WIDTH-1:0] eps_plan[5];
		localparam int ONE = 32'h0001_0000;
		localparam int MAXP = 32'h7FFF_FFFF;
		localparam int MAXN = 32'h8000_0000;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		eps_now = m3inv_pkg::EPS_RESET;
		no_idle = 1'b0;
		errors = 0;
		matrices_sent = 0;
		inverses_seen = 0;
		singular_seen = 0;
		quiet_cycles = 0;
		eps_writes = 0;

		// reset epsilon
		add_row(16'd1, pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1,
			{1'b0, pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE)});
		add_row(16'd1, '0, 1'b1, {1'b1, {DW{1'b0}}});
		add_row(16'd1, {9{MAXP}}, 1'b1, {1'b1, {9{MAXP}}});
		add_row(16'd1, {9{MAXN}}, 1'b1, {1'b1, {9{MAXN}}});
		add_row(16'd1, pack9(2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE), 1'b1,
			{1'b0, pack9(ONE/2, 0, 0, 0, ONE/2, 0, 0, 0, ONE/2)});
		add_row(16'd1, pack9(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1,
			{1'b1, pack9(1, 0, 0, 0, 1, 0, 0, 0, 1)});
		add_row(16'd1, pack9(ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 5*ONE, 6*ONE, 0), 1'b0, '0);
		add_row(16'd1, pack9(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE), 1'b0, '0);
		add_row(16'd1, pack9(MAXN, MAXP, 0, 3, MAXN, 7, MAXP, -5, MAXN), 1'b0, '0);
		add_row(16'd1, pack9(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE),
			1'b0, '0);
		// zero threshold: saturation both ways, plus a singular zero matrix and cases in range
		add_row(16'd0, pack9(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1,
			{1'b0, pack9(MAXP, 0, 0, 0, MAXP, 0, 0, 0, MAXP)});
		add_row(16'd0, pack9(-1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1,
			{1'b0, pack9(MAXN, 0, 0, 0, MAXP, 0, 0, 0, MAXP)});
		add_row(16'd0, '0, 1'b1, {1'b1, {DW{1'b0}}});
		add_row(16'd0, pack9(256, 0, 0, 0, 256, 0, 0, 0, 256), 1'b1,
			{1'b0, pack9(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000)});
		add_row(16'd0, pack9(3, -7, 1, 2, 5, -4, -6, 1, 9), 1'b0, '0);
		// top threshold: just above and just below
		add_row(16'hFFFF, pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1,
			{1'b0, pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE)});
		add_row(16'hFFFF, pack9(16'hFFFF, 0, 0, 0, 16'hFFFF, 0, 0, 0, 16'hFFFF), 1'b1,
			{1'b1, pack9(16'hFFFF, 0, 0, 0, 16'hFFFF, 0, 0, 0, 16'hFFFF)});
		add_row(16'hFFFF, pack9(2*ONE, ONE, 0, 0, 3*ONE, -ONE, ONE, 0, ONE), 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].eps != eps_now)
				write_epsilon(rows[i].eps);
			send_matrix(rows[i].mat, rows[i].typed, rows[i].want);
		end

		eps_plan = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom), 16'($urandom_range(1, 64))};
		for (int p = 0; p < 5; p++) begin
			write_epsilon(eps_plan[p]);
			for (int n = 0; n < 110; n++) begin
				no_idle = (p == 2 && n >= 20 && n < 90);
				// hold off until the pipe is empty
				if (p == 3 && n == 55)
					drain();
				send_matrix(random_matrix(), 1'b0, '0);
			end
		end
		no_idle = 1'b0;
		drain();
		repeat (LATENCY + 20) @(posedge clk);

		$display("Sent %0d matrices across %0d threshold writes; %0d results, %0d singular",
			matrices_sent, eps_writes, inverses_seen, singular_seen);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
